@@ rtl/bsnh_pkg.sv @@
`timescale 1ns / 1ps
// Package for the byte stream noise hash: word type, hash constants, the
// 32-entry noise table, the four swap pattern tables and the swap and scramble
// functions. Depends on nothing; every other file of the block imports it.
package bsnh_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned NOISE_IDX_W  = 5;
    localparam int unsigned NOISE_DEPTH  = 32;
    localparam int unsigned SCR_COUNT    = 4;
    localparam int unsigned SWAP_COUNT   = 16;

    localparam word_t HASH_INIT  = 32'hac3b843b;
    localparam word_t BYTE_MUL   = 32'd238;
    localparam word_t ROT_ADD    = 32'd1057592071;
    localparam int unsigned ROT_AMOUNT = 15;

    localparam logic [0:NOISE_DEPTH-1][31:0] NOISE_WORDS = '{
        32'h347cf746, 32'h7b840e02, 32'h4b6e3c4e, 32'h489b06c6,
        32'h2ba14c6e, 32'h4572434a, 32'h04600530, 32'h7f9acc78,
        32'h50a98955, 32'h071b0827, 32'h15690047, 32'h6c68f552,
        32'h5fc52edf, 32'h61ca273b, 32'h44e4c5f4, 32'h6a8f5fc5,
        32'h01fc910a, 32'h29e9de3f, 32'h2788c41e, 32'h6b5c5ce4,
        32'h39d672de, 32'h6d7680bf, 32'h511f385d, 32'h577fa18f,
        32'h7aa4ca0d, 32'h671710ed, 32'h127e0c78, 32'h567cb335,
        32'h65f0a296, 32'h3f0eaf85, 32'h4e838e1f, 32'h1a6d99dd
    };

    // Position pairs per scramble; element [1] is position a, element [0] is b.
    localparam logic [0:SCR_COUNT-1][0:SWAP_COUNT-1][1:0][4:0] SWAP_PAIRS = '{
        '{'{5'd23, 5'd16}, '{5'd25, 5'd13}, '{5'd15, 5'd10}, '{5'd6,  5'd19},
          '{5'd3,  5'd2},  '{5'd11, 5'd14}, '{5'd4,  5'd24}, '{5'd20, 5'd18},
          '{5'd7,  5'd30}, '{5'd0,  5'd29}, '{5'd9,  5'd28}, '{5'd1,  5'd17},
          '{5'd12, 5'd27}, '{5'd26, 5'd21}, '{5'd31, 5'd8},  '{5'd22, 5'd5}},
        '{'{5'd7,  5'd19}, '{5'd30, 5'd6},  '{5'd20, 5'd15}, '{5'd21, 5'd8},
          '{5'd24, 5'd12}, '{5'd9,  5'd14}, '{5'd0,  5'd25}, '{5'd1,  5'd17},
          '{5'd26, 5'd4},  '{5'd31, 5'd23}, '{5'd27, 5'd29}, '{5'd18, 5'd10},
          '{5'd2,  5'd16}, '{5'd28, 5'd13}, '{5'd11, 5'd22}, '{5'd5,  5'd3}},
        '{'{5'd28, 5'd30}, '{5'd10, 5'd31}, '{5'd4,  5'd26}, '{5'd19, 5'd8},
          '{5'd5,  5'd0},  '{5'd18, 5'd11}, '{5'd15, 5'd22}, '{5'd14, 5'd1},
          '{5'd17, 5'd23}, '{5'd16, 5'd29}, '{5'd27, 5'd7},  '{5'd9,  5'd12},
          '{5'd2,  5'd25}, '{5'd20, 5'd24}, '{5'd21, 5'd13}, '{5'd3,  5'd6}},
        '{'{5'd17, 5'd22}, '{5'd20, 5'd16}, '{5'd10, 5'd12}, '{5'd24, 5'd23},
          '{5'd21, 5'd5},  '{5'd19, 5'd27}, '{5'd18, 5'd15}, '{5'd14, 5'd8},
          '{5'd0,  5'd28}, '{5'd2,  5'd4},  '{5'd1,  5'd25}, '{5'd29, 5'd6},
          '{5'd26, 5'd31}, '{5'd13, 5'd30}, '{5'd9,  5'd11}, '{5'd3,  5'd7}}
    };

    // Two-bit swap as the hash defines it. When a is above b, bit a moves
    // further up and bit b further down, so bits can fall off either end.
    function automatic word_t swap_pair(word_t v, logic [4:0] a, logic [4:0] b);
        logic [4:0] s;
        word_t      ma;
        word_t      mb;
        s  = (a >= b) ? (a - b) : (b - a);
        ma = 32'd1 << a;
        mb = 32'd1 << b;
        return (v & ~(ma | mb)) | ((v & ma) << s) | ((v & mb) >> s);
    endfunction

    // OR of the sixteen swap results of one scramble pattern.
    function automatic word_t scramble(logic [1:0] sel, word_t v);
        word_t acc;
        acc = '0;
        for (int i = 0; i < SWAP_COUNT; i++)
        begin
            acc |= swap_pair(v, SWAP_PAIRS[sel][i][1], SWAP_PAIRS[sel][i][0]);
        end
        return acc;
    endfunction

endpackage

@@ rtl/bsnh_noise.sv @@
`timescale 1ns / 1ps
// One noise lookup: table word by index bits 4..0, subtract, then the
// scramble chosen by index bits 1..0. Depends on bsnh_pkg.
module bsnh_noise (
    input  bsnh_pkg::word_t x,
    output bsnh_pkg::word_t y
);
    import bsnh_pkg::*;

    word_t diff;
    word_t scr [SCR_COUNT];

    assign diff = x - NOISE_WORDS[x[NOISE_IDX_W-1:0]];

    // All four patterns are fixed wiring plus OR gates; pick one afterwards.
    always_comb
    begin
        for (int k = 0; k < SCR_COUNT; k++)
        begin
            scr[k] = scramble(2'(k), diff);
        end
    end

    always_comb
    begin
        case (x[1:0])
            2'd0:    y = scr[0];
            2'd1:    y = scr[1];
            2'd2:    y = scr[2];
            default: y = scr[3];
        endcase
    end

endmodule

@@ rtl/bsnh_round.sv @@
`timescale 1ns / 1ps
// Per-byte hash update: two noise-and-add steps on the running hash and one
// noise-and-xor step that depends on the byte alone. Depends on bsnh_pkg, bsnh_noise.
module bsnh_round (
    input  bsnh_pkg::word_t hash_cur,
    input  logic [7:0]      data_byte,
    output bsnh_pkg::word_t hash_new
);
    import bsnh_pkg::*;

    word_t byte_w;
    word_t x1, n1, h1;
    word_t x2, n2, h2;
    word_t sum3, x3, n3;

    assign byte_w = {24'd0, data_byte};

    assign x1 = {28'd0, data_byte[7:4]} + hash_cur;
    bsnh_noise u_noise1 (.x(x1), .y(n1));
    assign h1 = hash_cur + n1;

    assign x2 = h1 + 32'(byte_w * BYTE_MUL);
    bsnh_noise u_noise2 (.x(x2), .y(n2));
    assign h2 = h1 + n2;

    // Right rotation by a fixed amount is just wiring.
    assign sum3 = ROT_ADD + byte_w;
    assign x3   = (sum3 >> ROT_AMOUNT) | (sum3 << (32 - ROT_AMOUNT));
    bsnh_noise u_noise3 (.x(x3), .y(n3));

    assign hash_new = h2 ^ n3;

endmodule

@@ rtl/byte_stream_noise_hash.sv @@
`timescale 1ns / 1ps
// Top level of the byte stream noise hash: input register, per-byte update
// and result register. Depends on bsnh_pkg and bsnh_round.
//
// Usage
// -----
// The input channel (in_valid / in_ready) carries one message byte per beat,
// data_byte, with last_byte set on the final byte of a message. Every
// message is at least one byte long. The output channel (out_valid /
// out_ready) carries one beat per message, hash_value, the 32-bit hash over
// all its bytes; the running hash then starts over from its initial value.
//
// Throughput is one byte per clock cycle unless a last byte must wait. A beat
// that is not last lands in the input register and is folded into the
// running hash in the following cycle; the whole update (three noise lookups
// with their adds and the final xor) sits between the input register and the
// hash and result registers; for a last byte the result register drives the output.
//
// While the receiver stalls, bytes that are not last keep flowing into the
// hash. A last byte waits in the input register only while the result
// register still holds an untaken hash, and in_ready drops only then.
// Reset clears both valid flags and loads the running hash with its initial
// value; no beat is lost or duplicated across a stall.
module byte_stream_noise_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);
    import bsnh_pkg::*;

    // Input register.
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;

    // Running hash and result register.
    word_t hash_reg, hash_next;
    logic  out_valid_reg, out_valid_next;
    word_t result_reg;

    word_t hash_upd;
    logic  s1_advance;
    logic  in_fire;
    logic  out_fire;

    bsnh_round u_round (
        .hash_cur  (hash_reg),
        .data_byte (s1_data_reg),
        .hash_new  (hash_upd)
    );

    assign out_fire = out_valid_reg && out_ready;

    // A byte that is not last never needs the result register, so it always
    // moves on. A last byte needs the result register empty or being emptied.
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = in_fire || (s1_valid_reg && !s1_advance);
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && !out_fire;
        if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                hash_next      = HASH_INIT;
                out_valid_next = 1'b1;
            end
            else
            begin
                hash_next = hash_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hash_reg      <= HASH_INIT;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            hash_reg      <= hash_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_advance && s1_last_reg)
        begin
            result_reg <= hash_upd;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = result_reg;

    // The hash restarts after every last byte.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> (hash_reg == HASH_INIT && out_valid_reg))
        else $error("hash did not restart or result not posted after last byte");

    // The running hash only changes when a byte is folded in.
    a_hash_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(hash_reg))
        else $error("running hash changed without a byte");

    // A byte that is not last never creates a result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !(s1_advance && s1_last_reg)) |=> !out_valid_reg)
        else $error("result appeared without a last byte");

    // An empty input register always takes a beat.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with an empty input register");

endmodule
